// File: sv/bpdc_pkg.sv
package bpdc_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int LIMIT_W     = 26;
  localparam int MAX_RESULTS = 4;
  localparam int COUNT_W     = 3;

  localparam int UP_IDX   = 1;
  localparam int DOWN_IDX = 2;

  typedef logic [1:0] gesture_t;
  typedef logic [1:0] button_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  localparam gesture_t G_SHORT = 2'd0;
  localparam gesture_t G_LONG  = 2'd1;
  localparam gesture_t G_VLONG = 2'd2;
  localparam gesture_t G_COMBO = 2'd3;

  localparam logic [1:0] REG_SHORT = 2'd0;
  localparam logic [1:0] REG_LONG  = 2'd1;
  localparam logic [1:0] REG_VLONG = 2'd2;
  localparam logic [1:0] REG_COMBO = 2'd3;

  localparam limit_t SHORT_RESET = 26'd500000;
  localparam limit_t LONG_RESET  = 26'd1000000;
  localparam limit_t VLONG_RESET = 26'd3000000;
  localparam limit_t COMBO_RESET = 26'd2000000;

  typedef struct packed {
    gesture_t gesture;
    button_t  button;
  } result_t;

endpackage

// File: sv/button_press_duration_classifier_core.sv
// Button press-duration classifier.
// item channel: item_valid/item_stall with op, button_mask, now_us. Each word is one
//   timestamped sample of the mode/up/down mask; op=1 also checks held times.
// result channel: result_valid/result_stall with gesture, button, last. A sample gives
//   zero to four words; last marks the final word of a sample.
// cfg channel: cfg_valid/cfg_ready (always ready), cfg_index selects short, long,
//   very-long or combo limit, cfg_data is the 26-bit limit in microseconds.
// Timing: a sample is first registered into the evaluation stage and is then evaluated,
//   loading the result buffer; its first word is presented right after that load.
// Throughput: one sample per cycle while each sample gives at most one word and
//   result_stall is low. A sample that gives words waits in the evaluation stage until
//   the 4-entry result buffer, draining one word per cycle while not stalled, is empty
//   or its last word is being taken; samples with no words pass without waiting.
// Reset clears all button and combo state, empties the pipeline and loads the
//   default limits. When result_stall is high the presented word holds; the
//   evaluation stage then waits if its sample gives words, and item_stall is high while it waits.
module button_press_duration_classifier_core
  import bpdc_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  op,
  input  logic [2:0]            button_mask,
  input  logic [TIME_WIDTH-1:0] now_us,
  output logic                  result_valid,
  input  logic                  result_stall,
  output gesture_t              gesture,
  output button_t               button,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  limit_t                cfg_data
);

  typedef logic [TIME_WIDTH-1:0] time_t;

  limit_t short_limit, long_limit, vlong_limit, combo_limit;

  logic       s1_valid;
  logic       s1_op;
  logic [2:0] s1_mask;
  time_t      s1_now;

  logic [2:0] prev_mask;
  time_t      press [NUM_BUTTONS];
  logic [2:0] ld, vld;
  time_t      combo_start;
  logic       combo_running, combo_done;

  result_t      rbuf [MAX_RESULTS];
  logic [COUNT_W-1:0] rcount;

  logic [2:0] rise, fall, short_fire, vl_fire, l_fire, ld_e, vld_e;
  time_t      held [NUM_BUTTONS];
  time_t      held2 [NUM_BUTTONS];
  time_t      press_next [NUM_BUTTONS];
  logic [2:0] ld_next, vld_next;
  logic       both, c_fire;
  time_t      held_c, combo_start_next;
  logic       combo_done_next;

  logic [6:0] cand_v;
  result_t    cand [7];
  result_t    list [MAX_RESULTS];
  logic [COUNT_W-1:0] n_res;

  logic item_take, res_take, buf_free, go;

  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      rise[i]  = ~prev_mask[i] & s1_mask[i];
      fall[i]  = prev_mask[i] & ~s1_mask[i];
      held[i]  = s1_now - press[i];
      short_fire[i] = fall[i] & ~ld[i] & ~vld[i] & (held[i] < time_t'(short_limit));
      held2[i] = rise[i] ? '0 : held[i];
      ld_e[i]  = rise[i] ? 1'b0 : ld[i];
      vld_e[i] = rise[i] ? 1'b0 : vld[i];
      vl_fire[i] = s1_op & s1_mask[i] & ~vld_e[i] & (held2[i] >= time_t'(vlong_limit));
      l_fire[i]  = s1_op & s1_mask[i] & ~vl_fire[i] & ~ld_e[i]
                   & (held2[i] >= time_t'(long_limit));
      press_next[i] = rise[i] ? s1_now : (fall[i] ? '0 : press[i]);
      ld_next[i]  = ld_e[i] | vl_fire[i] | l_fire[i];
      vld_next[i] = vld_e[i] | vl_fire[i];
    end
  end

  assign both   = s1_mask[UP_IDX] & s1_mask[DOWN_IDX];
  assign held_c = combo_running ? (s1_now - combo_start) : '0;
  assign c_fire = s1_op & both & ~combo_done & (held_c >= time_t'(combo_limit));
  assign combo_start_next = both ? (combo_running ? combo_start : s1_now) : '0;
  assign combo_done_next  = both & (combo_done | c_fire);

  // candidate order: shorts by button, then long/very-long by button, then combo
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      cand_v[i]                 = short_fire[i];
      cand[i].gesture           = G_SHORT;
      cand[i].button            = button_t'(i);
      cand_v[NUM_BUTTONS+i]       = vl_fire[i] | l_fire[i];
      cand[NUM_BUTTONS+i].gesture = vl_fire[i] ? G_VLONG : G_LONG;
      cand[NUM_BUTTONS+i].button  = button_t'(i);
    end
    cand_v[6]       = c_fire;
    cand[6].gesture = G_COMBO;
    cand[6].button  = '0;
  end

  always_comb begin
    n_res = '0;
    for (int k = 0; k < MAX_RESULTS; k++) list[k] = cand[6];
    for (int k = 0; k < 7; k++) begin
      if (cand_v[k]) begin
        list[n_res[1:0]] = cand[k];
        n_res = n_res + COUNT_W'(1);
      end
    end
  end

  assign res_take   = result_valid & ~result_stall;
  assign buf_free   = (rcount == '0) || ((rcount == COUNT_W'(1)) && !result_stall);
  assign go         = s1_valid & ((n_res == '0) | buf_free);
  assign item_stall = s1_valid & ~go;
  assign item_take  = item_valid & ~item_stall;

  assign result_valid = (rcount != '0);
  assign gesture      = rbuf[0].gesture;
  assign button       = rbuf[0].button;
  assign last         = (rcount == COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      short_limit <= SHORT_RESET;
      long_limit  <= LONG_RESET;
      vlong_limit <= VLONG_RESET;
      combo_limit <= COMBO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHORT: short_limit <= cfg_data;
        REG_LONG:  long_limit  <= cfg_data;
        REG_VLONG: vlong_limit <= cfg_data;
        REG_COMBO: combo_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_op   <= op;
      s1_mask <= button_mask;
      s1_now  <= now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mask     <= '0;
      ld            <= '0;
      vld           <= '0;
      combo_start   <= '0;
      combo_running <= 1'b0;
      combo_done    <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) press[i] <= '0;
    end else if (go) begin
      prev_mask     <= s1_mask;
      ld            <= ld_next;
      vld           <= vld_next;
      combo_start   <= combo_start_next;
      combo_running <= both;
      combo_done    <= combo_done_next;
      for (int i = 0; i < NUM_BUTTONS; i++) press[i] <= press_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcount <= '0;
    end else if (go && (n_res != '0)) begin
      rcount <= n_res;
    end else if (res_take) begin
      rcount <= rcount - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (go && (n_res != '0)) begin
      for (int k = 0; k < MAX_RESULTS; k++) rbuf[k] <= list[k];
    end else if (res_take) begin
      for (int k = 0; k < MAX_RESULTS - 1; k++) rbuf[k] <= rbuf[k+1];
    end
  end

endmodule

// File: sv/bpdc_checker.sv
module bpdc_checker
  import bpdc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     result_valid,
  input logic     result_stall,
  input gesture_t gesture,
  input button_t  button,
  input logic     last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word present after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(gesture)
      && $stable(button) && $stable(last))
    else $error("stalled result word changed");

  a_combo_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (gesture == G_COMBO) |-> last && (button == '0))
    else $error("combo word not final or has nonzero button");

  a_button_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (button != 2'd3))
    else $error("button index out of range");

endmodule

bind button_press_duration_classifier_core bpdc_checker u_bpdc_checker (
  .clk(clk),
  .rst(rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .gesture(gesture),
  .button(button),
  .last(last)
);

// File: verif/tb_top.sv
module tb_top;
  import bpdc_pkg::*;

  localparam int TIME_W = 48;
  localparam logic OP_EDGES = 1'b0;
  localparam logic OP_CHECK = 1'b1;
  localparam limit_t LIMIT_MAX = '1;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 2000;

  typedef struct packed {
    logic              op;
    logic [2:0]        mask;
    logic [TIME_W-1:0] now;
  } sample_t;

  typedef struct packed {
    gesture_t gesture;
    button_t  button;
    logic     last;
  } gesture_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic              op = OP_EDGES;
  logic [2:0]        button_mask = '0;
  logic [TIME_W-1:0] now_us = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  gesture_t          gesture;
  button_t           button;
  logic              last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = REG_SHORT;
  limit_t            cfg_data = '0;

  button_press_duration_classifier_core #(.TIME_WIDTH(TIME_W)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .button_mask  (button_mask),
    .now_us       (now_us),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .gesture      (gesture),
    .button       (button),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // classifier model state
  limit_t            lim_short = SHORT_RESET;
  limit_t            lim_long  = LONG_RESET;
  limit_t            lim_vlong = VLONG_RESET;
  limit_t            lim_combo = COMBO_RESET;
  logic [2:0]        held_mask = '0;
  logic [TIME_W-1:0] press_at [NUM_BUTTONS] = '{default: '0};
  logic              long_fired [NUM_BUTTONS] = '{default: 1'b0};
  logic              vlong_fired [NUM_BUTTONS] = '{default: 1'b0};
  logic [TIME_W-1:0] combo_at = '0;
  logic              combo_on = 1'b0;
  logic              combo_fired = 1'b0;

  sample_t       pending_samples [$];
  gesture_word_t gesture_q [$];
  gesture_word_t want;
  sample_t       cur;
  int            queued_cnt = 0;
  int            taken_cnt = 0;
  int            err_cnt = 0;
  int            send_wait = 0;
  int            recv_wait = 0;
  bit            send_gaps_on = 1'b1;
  bit            recv_gaps_on = 1'b1;
  bit            hold_req = 1'b0;
  bit            hold_used = 1'b0;
  int            hold_left = 0;
  logic [2:0]        gen_mask = '0;
  logic [TIME_W-1:0] gen_now = '0;

  function automatic void classify_sample(input sample_t s);
    logic [TIME_W-1:0] held;
    gesture_word_t     words [$];
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (!held_mask[i] && s.mask[i]) begin
        press_at[i] = s.now;
        long_fired[i] = 1'b0;
        vlong_fired[i] = 1'b0;
      end else if (held_mask[i] && !s.mask[i]) begin
        held = s.now - press_at[i];
        if (!long_fired[i] && !vlong_fired[i] && held < TIME_W'(lim_short))
          words.push_back('{G_SHORT, button_t'(i), 1'b0});
        press_at[i] = '0;
      end
    end
    if (s.mask[UP_IDX] && s.mask[DOWN_IDX]) begin
      if (!combo_on) begin
        combo_at = s.now;
        combo_on = 1'b1;
      end
    end else begin
      combo_at = '0;
      combo_on = 1'b0;
      combo_fired = 1'b0;
    end
    held_mask = s.mask;
    if (s.op == OP_CHECK) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (held_mask[i]) begin
          held = s.now - press_at[i];
          if (!vlong_fired[i] && held >= TIME_W'(lim_vlong)) begin
            vlong_fired[i] = 1'b1;
            long_fired[i] = 1'b1;
            words.push_back('{G_VLONG, button_t'(i), 1'b0});
          end else if (!long_fired[i] && held >= TIME_W'(lim_long)) begin
            long_fired[i] = 1'b1;
            words.push_back('{G_LONG, button_t'(i), 1'b0});
          end
        end
      end
      held = s.now - combo_at;
      if (combo_on && !combo_fired && held >= TIME_W'(lim_combo)) begin
        combo_fired = 1'b1;
        words.push_back('{G_COMBO, button_t'(0), 1'b0});
      end
    end
    if (words.size() > 0)
      words[words.size()-1].last = 1'b1;
    foreach (words[k])
      gesture_q.push_back(words[k]);
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!(item_valid && item_stall)) begin
      if (send_wait > 0) begin
        send_wait--;
        item_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        cur = pending_samples.pop_front();
        op <= cur.op;
        button_mask <= cur.mask;
        now_us <= cur.now;
        item_valid <= 1'b1;
        send_wait = send_gaps_on ? $urandom_range(0, 11) : 0;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result monitor; also predicts each accepted sample after checking
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (gesture_q.size() == 0) begin
          $error("unexpected word: gesture %0d button %0d last %0d", gesture, button, last);
          err_cnt++;
        end else begin
          want = gesture_q.pop_front();
          if (gesture !== want.gesture) begin
            $error("gesture: expected %0d, got %0d", want.gesture, gesture);
            err_cnt++;
          end
          if (button !== want.button) begin
            $error("button: expected %0d, got %0d", want.button, button);
            err_cnt++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            err_cnt++;
          end
        end
        recv_wait = recv_gaps_on ? $urandom_range(0, 11) : 0;
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      if (item_valid && !item_stall) begin
        classify_sample('{op, button_mask, now_us});
        taken_cnt <= taken_cnt + 1;
      end
      result_stall <= (recv_wait > 0) || (hold_left > 0);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic add_sample(input logic o, input logic [2:0] m, input logic [TIME_W-1:0] t);
    pending_samples.push_back('{o, m, t});
    queued_cnt++;
  endtask

  task automatic write_limit(input logic [1:0] idx, input limit_t val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SHORT: lim_short = val;
      REG_LONG:  lim_long  = val;
      REG_VLONG: lim_vlong = val;
      REG_COMBO: lim_combo = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (taken_cnt != queued_cnt) @(posedge clk);
    while (gesture_q.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (gesture_q.size() > 0) begin
      $error("%0d expected words never arrived", gesture_q.size());
      err_cnt++;
      gesture_q.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic add_random(input int n, input int unsigned step_max);
    int unsigned sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 39);
      if (sel == 0)
        gen_now = TIME_W'({$urandom, $urandom});
      else if (sel == 1)
        gen_now = gen_now - TIME_W'($urandom_range(1, step_max));
      else
        gen_now = gen_now + TIME_W'($urandom_range(0, step_max));
      if (sel == 2)
        gen_mask = 3'($urandom);
      else if (sel == 3 || sel == 4)
        gen_mask = gen_mask | 3'b110;
      else if ($urandom_range(0, 2) == 0)
        gen_mask = gen_mask ^ (3'b001 << $urandom_range(0, 2));
      add_sample(($urandom_range(0, 3) != 0) ? OP_CHECK : OP_EDGES, gen_mask, gen_now);
    end
  endtask

  task automatic run_phase(input limit_t s, input limit_t l, input limit_t v, input limit_t c,
                           input int n, input int unsigned step_max,
                           input bit sgaps, input bit rgaps, input bit pressure);
    write_limit(REG_SHORT, s);
    write_limit(REG_LONG, l);
    write_limit(REG_VLONG, v);
    write_limit(REG_COMBO, c);
    cfg_valid <= 1'b0;
    @(negedge clk);
    send_gaps_on = sgaps;
    recv_gaps_on = rgaps;
    hold_req = pressure;
    add_random(n, step_max);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limits: edges, exact thresholds, time zero, backwards time, wrap
    add_sample(OP_CHECK, 3'b000, 48'd0);
    add_sample(OP_EDGES, 3'b001, 48'd0);
    add_sample(OP_EDGES, 3'b000, 48'd100);
    add_sample(OP_CHECK, 3'b010, 48'd1000);
    add_sample(OP_CHECK, 3'b010, 48'd1001000);
    add_sample(OP_CHECK, 3'b010, 48'd3001000);
    add_sample(OP_EDGES, 3'b000, 48'd3100000);
    add_sample(OP_CHECK, 3'b111, 48'd0);
    add_sample(OP_CHECK, 3'b111, 48'd3000000);
    add_sample(OP_CHECK, 3'b111, 48'd3500000);
    add_sample(OP_CHECK, 3'b000, 48'd3600000);
    add_sample(OP_EDGES, 3'b111, 48'd4000000);
    add_sample(OP_CHECK, 3'b000, 48'd4000010);
    add_sample(OP_EDGES, 3'b001, 48'd5000000);
    add_sample(OP_EDGES, 3'b000, 48'd5500000);
    add_sample(OP_EDGES, 3'b001, 48'd6000000);
    add_sample(OP_EDGES, 3'b000, 48'd6499999);
    add_sample(OP_CHECK, 3'b100, 48'd7000000);
    add_sample(OP_CHECK, 3'b100, 48'd8000000);
    add_sample(OP_CHECK, 3'b101, 48'd8999999);
    add_sample(OP_CHECK, 3'b101, 48'd8999998);
    add_sample(OP_CHECK, 3'b010, 48'hFFFF_FFFF_FFF0);
    add_sample(OP_CHECK, 3'b110, 48'h10);
    add_sample(OP_EDGES, 3'b000, 48'hFFFF_FFFF_FFFF);
    add_sample(OP_CHECK, 3'b110, 48'd0);
    add_sample(OP_CHECK, 3'b110, 48'd2000000);
    drain();

    gen_now = 48'd20000000;
    run_phase('0, '0, '0, '0, 35, 50, 1'b0, 1'b0, 1'b0);
    run_phase(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 35, 32'd1 << 25,
              1'b1, 1'b1, 1'b0);
    run_phase(26'd200, 26'd500, 26'd900, 26'd700, 50, 400, 1'b0, 1'b1, 1'b1);
    run_phase(limit_t'($urandom_range(0, 2000)), limit_t'($urandom_range(0, 2000)),
              limit_t'($urandom_range(0, 2000)), limit_t'($urandom_range(0, 2000)),
              45, 800, 1'b1, 1'b1, 1'b0);
    run_phase(limit_t'($urandom), limit_t'($urandom), limit_t'($urandom),
              limit_t'($urandom), 40, 32'd1 << 24, 1'b1, 1'b0, 1'b0);

    if (err_cnt == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
